>>> rtl/sha_pkg.sv
// Shared types, constants and round functions of the SHA-256 message hasher.
`default_nettype none
package sha_pkg;

	localparam int LENGTH_COUNTER_BITS = 64;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [31:0] message_word;
		logic [2:0]  valid_bytes;
		logic        final_word;
	} msg_beat_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  digest_index;
		logic        digest_last;
	} digest_beat_t;

	// One block word from the front part; last marks the final word of a message.
	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} blk_beat_t;

	typedef enum logic [2:0] {
		FE_IDLE,
		FE_MARK,
		FE_ZERO,
		FE_LENHI,
		FE_LENLO
	} fe_state_t;

	typedef enum logic [1:0] {
		BE_FILL,
		BE_ROUND,
		BE_ADD,
		BE_OUT
	} be_state_t;

	localparam logic [3:0] LEN_HI_POS = 4'd14;
	localparam logic [2:0] FULL_BYTES = 3'd4;
	localparam logic [31:0] PAD_MARK = 32'h8000_0000;

	localparam logic [31:0] INITIAL_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
			input logic [31:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage
`default_nettype wire

>>> rtl/sha256_message_hasher_top.sv
// Top level of the streaming SHA-256 message hasher.
// Usage:
// Message beats go in on message with push/full: a beat is taken at a clock edge with
// push high and full low. Each beat carries one big-endian word, its count of valid
// leading bytes and a final flag; a final beat with count zero ends an empty message.
// Digest beats come out on digest with empty/pop: the oldest beat stands while empty
// is low and is taken on an edge with pop high. Eight beats, index 0 first, follow
// every final beat; digest_last marks the eighth.
// Each 16-word block is gathered from the internal queue, run through 64 rounds in
// the single round unit and folded into the chaining words; no new block word is
// taken meanwhile. Padding completes the open block or adds one more.
// The first digest beat after a final beat waits longer when the padding needs a
// second block, and longer while the back part is still busy with earlier words.
// While the receiver stalls the digest, the front part keeps taking beats until the
// four-entry queue fills, then holds full high. The back part resumes after the last
// digest beat. Reset sets the chaining words to the initial values, clears the length
// count and the queue; no clearing pass is needed.
`default_nettype none
module sha256_message_hasher_top (
	input  wire                   clk,
	input  wire                   arst_n,
	input  sha_pkg::msg_beat_t    message,
	input  wire                   push,
	output logic                  full,
	output sha_pkg::digest_beat_t digest,
	output logic                  empty,
	input  wire                   pop
);

	sha_pkg::blk_beat_t wr_data, rd_data;
	logic q_wr, q_full, q_rd, q_empty;

	sha_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.message(message),
		.push   (push),
		.full   (full),
		.q_data (wr_data),
		.q_wr   (q_wr),
		.q_full (q_full)
	);

	sha_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_data(wr_data),
		.wr     (q_wr),
		.full   (q_full),
		.rd_data(rd_data),
		.rd     (q_rd),
		.empty  (q_empty)
	);

	sha_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_data (rd_data),
		.q_empty(q_empty),
		.q_rd   (q_rd),
		.digest (digest),
		.empty  (empty),
		.pop    (pop)
	);

endmodule
`default_nettype wire

>>> rtl/sha_front.sv
// Front part: takes message beats, counts the bit length and emits padded block words.
`default_nettype none
module sha_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  sha_pkg::msg_beat_t   message,
	input  wire                  push,
	output logic                 full,
	output sha_pkg::blk_beat_t   q_data,
	output logic                 q_wr,
	input  wire                  q_full
);

	sha_pkg::fe_state_t state_q, state_d;
	logic [3:0] pos_q;
	logic [sha_pkg::LENGTH_COUNTER_BITS-1:0] len_q, len_d;
	logic [2:0] cnt;
	logic [5:0] shamt;
	logic [31:0] keep;
	logic [63:0] len64;
	logic accept;

	assign full = (state_q != sha_pkg::FE_IDLE) || q_full;
	assign accept = push && !full;
	assign cnt = (message.valid_bytes > sha_pkg::FULL_BYTES) ? sha_pkg::FULL_BYTES
		: message.valid_bytes;
	assign shamt = {cnt, 3'b000};
	assign keep = ~(32'hffff_ffff >> shamt);
	assign len64 = 64'(len_q);

	always_comb begin
		state_d = state_q;
		len_d = len_q;
		q_wr = 1'b0;
		q_data.word = 32'h0;
		q_data.last = 1'b0;
		case (state_q)
			sha_pkg::FE_IDLE: begin
				if (accept) begin
					q_wr = 1'b1;
					if (!message.final_word) begin
						q_data.word = message.message_word;
						len_d = len_q + sha_pkg::LENGTH_COUNTER_BITS'(32);
					end else begin
						len_d = len_q + sha_pkg::LENGTH_COUNTER_BITS'(shamt);
						if (cnt == sha_pkg::FULL_BYTES) begin
							q_data.word = message.message_word;
							state_d = sha_pkg::FE_MARK;
						end else begin
							q_data.word = (message.message_word & keep)
								| (sha_pkg::PAD_MARK >> shamt);
							state_d = sha_pkg::FE_ZERO;
						end
					end
				end
			end
			sha_pkg::FE_MARK: begin
				if (!q_full) begin
					q_wr = 1'b1;
					q_data.word = sha_pkg::PAD_MARK;
					state_d = sha_pkg::FE_ZERO;
				end
			end
			sha_pkg::FE_ZERO: begin
				// Fill with zeros, wrapping into a new block if needed, up to the length slot.
				if (pos_q == sha_pkg::LEN_HI_POS) begin
					state_d = sha_pkg::FE_LENHI;
				end else if (!q_full) begin
					q_wr = 1'b1;
				end
			end
			sha_pkg::FE_LENHI: begin
				if (!q_full) begin
					q_wr = 1'b1;
					q_data.word = len64[63:32];
					state_d = sha_pkg::FE_LENLO;
				end
			end
			sha_pkg::FE_LENLO: begin
				if (!q_full) begin
					q_wr = 1'b1;
					q_data.word = len64[31:0];
					q_data.last = 1'b1;
					len_d = '0;
					state_d = sha_pkg::FE_IDLE;
				end
			end
			default: begin
				state_d = sha_pkg::FE_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::FE_IDLE;
			pos_q <= 4'd0;
			len_q <= '0;
		end else begin
			state_q <= state_d;
			len_q <= len_d;
			if (q_wr) begin
				pos_q <= pos_q + 4'd1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/sha_queue.sv
// Short queue of block words between the front and back parts.
`default_nettype none
module sha_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  sha_pkg::blk_beat_t   wr_data,
	input  wire                  wr,
	output logic                 full,
	output sha_pkg::blk_beat_t   rd_data,
	input  wire                  rd,
	output logic                 empty
);

	sha_pkg::blk_beat_t mem_q [sha_pkg::QUEUE_DEPTH];
	logic [sha_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [sha_pkg::QUEUE_PTR_BITS:0] count_q;
	logic do_wr, do_rd;

	assign full = (count_q == (sha_pkg::QUEUE_PTR_BITS+1)'(sha_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/sha_back.sv
// Back part: gathers block words, runs the 64 rounds and delivers the digest words.
`default_nettype none
module sha_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  sha_pkg::blk_beat_t   q_data,
	input  wire                  q_empty,
	output logic                 q_rd,
	output sha_pkg::digest_beat_t digest,
	output logic                 empty,
	input  wire                  pop
);

	sha_pkg::be_state_t state_q, state_d;
	logic [31:0] h_q [8];
	logic [31:0] work_q [8];
	logic [31:0] w_q [16];
	logic [3:0] fill_q;
	logic [5:0] rnd_q;
	logic [2:0] idx_q;
	logic last_q;
	logic [31:0] t1, t2, w_new;
	logic take_beat;

	assign q_rd = (state_q == sha_pkg::BE_FILL) && !q_empty;
	assign empty = (state_q != sha_pkg::BE_OUT);
	assign take_beat = pop && !empty;
	assign digest.digest_word = h_q[idx_q];
	assign digest.digest_index = idx_q;
	assign digest.digest_last = (idx_q == 3'd7);

	assign t1 = work_q[7] + sha_pkg::big_sigma1(work_q[4])
		+ sha_pkg::choose(work_q[4], work_q[5], work_q[6]) + sha_pkg::ROUND_K[rnd_q] + w_q[0];
	assign t2 = sha_pkg::big_sigma0(work_q[0]) + sha_pkg::majority(work_q[0], work_q[1], work_q[2]);
	assign w_new = w_q[0] + sha_pkg::small_sigma0(w_q[1]) + w_q[9] + sha_pkg::small_sigma1(w_q[14]);

	always_comb begin
		state_d = state_q;
		case (state_q)
			sha_pkg::BE_FILL: begin
				if (q_rd && (fill_q == 4'd15)) begin
					state_d = sha_pkg::BE_ROUND;
				end
			end
			sha_pkg::BE_ROUND: begin
				if (rnd_q == 6'd63) begin
					state_d = sha_pkg::BE_ADD;
				end
			end
			sha_pkg::BE_ADD: begin
				state_d = last_q ? sha_pkg::BE_OUT : sha_pkg::BE_FILL;
			end
			sha_pkg::BE_OUT: begin
				if (take_beat && digest.digest_last) begin
					state_d = sha_pkg::BE_FILL;
				end
			end
			default: begin
				state_d = sha_pkg::BE_FILL;
			end
		endcase
	end

	// Schedule window and working variables carry no reset.
	always_ff @(posedge clk) begin
		if (q_rd) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= q_data.word;
			if (fill_q == 4'd15) begin
				last_q <= q_data.last;
				for (int i = 0; i < 8; i++) begin
					work_q[i] <= h_q[i];
				end
			end
		end else if (state_q == sha_pkg::BE_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::BE_FILL;
			fill_q <= 4'd0;
			rnd_q <= 6'd0;
			idx_q <= 3'd0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha_pkg::INITIAL_H[i];
			end
		end else begin
			state_q <= state_d;
			if (q_rd) begin
				fill_q <= fill_q + 4'd1;
			end
			if (state_q == sha_pkg::BE_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (state_q == sha_pkg::BE_ADD) begin
				idx_q <= 3'd0;
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + work_q[i];
				end
			end
			if (take_beat) begin
				idx_q <= idx_q + 3'd1;
				// Restart the chain for the next message after the last digest beat.
				if (digest.digest_last) begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= sha_pkg::INITIAL_H[i];
					end
				end
			end
		end
	end

endmodule
`default_nettype wire
